// ===== hdl/msac_pkg.sv =====
package msac_pkg;

  localparam int DEF_NUM_SETS       = 16;
  localparam int DEF_NUM_WAYS       = 4;
  localparam int DEF_WORDS_PER_LINE = 4;
  localparam int DEF_ADDR_BITS      = 16;

  localparam logic [1:0] RT_READ  = 2'd0;
  localparam logic [1:0] RT_WRITE = 2'd1;
  localparam logic [1:0] RT_FILL  = 2'd2;
  localparam logic [1:0] RT_BAD   = 2'd3;

  localparam logic [2:0] RK_READ   = 3'd0;
  localparam logic [2:0] RK_WDONE  = 3'd1;
  localparam logic [2:0] RK_BUSREQ = 3'd2;
  localparam logic [2:0] RK_WBWORD = 3'd3;
  localparam logic [2:0] RK_REJECT = 3'd4;

  localparam logic [1:0] BC_NONE = 2'd0;
  localparam logic [1:0] BC_RD   = 2'd1;
  localparam logic [1:0] BC_RDX  = 2'd2;
  localparam logic [1:0] BC_UPG  = 2'd3;

  localparam logic [1:0] MS_I = 2'd0;
  localparam logic [1:0] MS_S = 2'd1;
  localparam logic [1:0] MS_E = 2'd2;
  localparam logic [1:0] MS_M = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [63:0] data_word;
    logic        bus_shared;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  resp_kind;
    logic [1:0]  bus_cmd;
    logic [15:0] out_addr;
    logic [63:0] out_data;
    logic        was_hit;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_RDH, ST_UPG, ST_WDONE,
    ST_WBRD, ST_WBOUT, ST_BREQ, ST_FILL, ST_REJ
  } state_t;

endpackage

// ===== hdl/mesi_set_assoc_cache.sv =====
// Steps: each read or write first reads its tag row (ST_LOOK). A read hit then reads
// its data word (ST_RDH); a write hit on a shared line sends an upgrade (ST_UPG)
// before its done result (ST_WDONE); a miss reads and sends each dirty victim word
// (ST_WBRD, ST_WBOUT) before its bus request (ST_BREQ). A fill word is written at
// once; the last one gives its result from ST_FILL, and a reject from ST_REJ. The tag memory
// read-modify-write sets these steps. One item is worked on at a time; the next
// item is taken once the last result of the previous one is in the output register.
// Reset (rst_n low, synchronous) starts a clearing pass over every set of the tag
// memory, during which no item is accepted.
module mesi_set_assoc_cache #(
  parameter int NUM_SETS       = msac_pkg::DEF_NUM_SETS,
  parameter int NUM_WAYS       = msac_pkg::DEF_NUM_WAYS,
  parameter int WORDS_PER_LINE = msac_pkg::DEF_WORDS_PER_LINE,
  parameter int ADDR_BITS      = msac_pkg::DEF_ADDR_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msac_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output msac_pkg::out_item_t out_item
);
  import msac_pkg::*;

  // Address split. Set count and line length must be powers of two; the block does not check this.
  localparam int SH_O = $clog2(WORDS_PER_LINE);
  localparam int SH_S = $clog2(NUM_SETS);
  localparam int W_O  = (SH_O > 0) ? SH_O : 1;
  localparam int W_S  = (SH_S > 0) ? SH_S : 1;
  localparam int W_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int W_T  = 16 - SH_O - SH_S;
  localparam int DA   = W_S + W_W + W_O;
  localparam logic [15:0] AMASK = (ADDR_BITS >= 16) ? 16'hFFFF :
                                  16'((32'd1 << ADDR_BITS) - 32'd1);

  // One tag memory row holds the state of every way of a set.
  typedef struct packed {
    logic           v;
    logic [1:0]     mesi;
    logic           d;
    logic [7:0]     age;
    logic [W_T-1:0] tag;
  } way_t;
  typedef way_t [NUM_WAYS-1:0] row_t;

  function automatic logic [W_O-1:0] f_off(logic [15:0] a);
    return W_O'(a & 16'(WORDS_PER_LINE - 1));
  endfunction

  function automatic logic [W_S-1:0] f_set(logic [15:0] a);
    return W_S'((a >> SH_O) & 16'(NUM_SETS - 1));
  endfunction

  function automatic logic [W_T-1:0] f_tag(logic [15:0] a);
    return W_T'(a >> (SH_O + SH_S));
  endfunction

  function automatic logic [15:0] f_base(logic [W_T-1:0] t, logic [W_S-1:0] s);
    return (16'(t) << (SH_O + SH_S)) | ((16'(s) & 16'(NUM_SETS - 1)) << SH_O);
  endfunction

  function automatic logic [DA-1:0] f_idx(logic [W_S-1:0] s, logic [W_W-1:0] w,
                                          logic [W_O-1:0] o);
    return {s, w, o};
  endfunction

  // Every valid way ages by one, saturating; the touched way restarts at zero.
  function automatic row_t f_touch(row_t r, logic [W_W-1:0] w);
    row_t t;
    t = r;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (t[i].v && t[i].age != 8'hFF) begin
        t[i].age = t[i].age + 8'd1;
      end
    end
    t[w].age = 8'd0;
    return t;
  endfunction

  // Memories.
  row_t            tag_mem [NUM_SETS];
  logic [63:0]     dat_mem [2**DA];
  logic            row_re, row_we, dm_re, dm_we;
  logic [W_S-1:0]  row_raddr, row_waddr;
  row_t            row_wdata, row_q;
  logic [DA-1:0]   dm_raddr, dm_waddr;
  logic [63:0]     dm_wdata, dm_q;

  always_ff @(posedge clk) begin
    if (row_we) begin
      tag_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_q <= tag_mem[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dat_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_q <= dat_mem[dm_raddr];
    end
  end

  // Control and pending-miss registers.
  state_t          state_r, state_nxt;
  in_item_t        req_r, req_nxt;
  logic            pend_r, pend_nxt;
  logic            pwr_r, pwr_nxt;
  logic [15:0]     paddr_r, paddr_nxt;
  logic [63:0]     pval_r, pval_nxt;
  logic [W_W-1:0]  vict_r, vict_nxt;
  logic [W_O-1:0]  fcnt_r, fcnt_nxt;
  logic [W_O-1:0]  wbk_r, wbk_nxt;
  logic [W_T-1:0]  wbtag_r, wbtag_nxt;
  logic [W_S-1:0]  clr_r, clr_nxt;
  logic            out_valid_r;
  out_item_t       out_item_r;
  logic            out_load;
  out_item_t       out_val;
  logic            can_load;

  // Lookup results over the row just read.
  logic            hit;
  logic [W_W-1:0]  hit_way;
  logic            have_inv;
  logic [W_W-1:0]  inv_way, old_way, victim;
  logic [7:0]      best_age;
  logic            have_old;
  logic            need_wb;
  in_item_t        acc_item;
  logic [63:0]     fill_word;
  row_t            row_mod;

  assign can_load  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    hit      = 1'b0;
    hit_way  = '0;
    have_inv = 1'b0;
    inv_way  = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (row_q[i].v && row_q[i].tag == f_tag(req_r.addr)) begin
        hit     = 1'b1;
        hit_way = W_W'(i);
      end
      if (!row_q[i].v) begin
        have_inv = 1'b1;
        inv_way  = W_W'(i);
      end
    end
    have_old = 1'b0;
    best_age = 8'd0;
    old_way  = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (!have_old || row_q[i].age > best_age) begin
        have_old = 1'b1;
        best_age = row_q[i].age;
        old_way  = W_W'(i);
      end
    end
    victim  = have_inv ? inv_way : old_way;
    need_wb = row_q[victim].v && (row_q[victim].d || row_q[victim].mesi == MS_M);
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    pend_nxt  = pend_r;
    pwr_nxt   = pwr_r;
    paddr_nxt = paddr_r;
    pval_nxt  = pval_r;
    vict_nxt  = vict_r;
    fcnt_nxt  = fcnt_r;
    wbk_nxt   = wbk_r;
    wbtag_nxt = wbtag_r;
    clr_nxt   = clr_r;
    row_re    = 1'b0;
    row_raddr = f_set(req_r.addr);
    row_we    = 1'b0;
    row_waddr = f_set(req_r.addr);
    row_wdata = row_q;
    dm_re     = 1'b0;
    dm_raddr  = '0;
    dm_we     = 1'b0;
    dm_waddr  = '0;
    dm_wdata  = req_r.data_word;
    out_load  = 1'b0;
    out_val   = '0;
    acc_item  = in_item;
    acc_item.addr = in_item.addr & AMASK;
    fill_word = (f_off(paddr_r) == W_O'(WORDS_PER_LINE - 1)) ? req_r.data_word : dm_q;
    row_mod   = row_q;

    case (state_r)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_r;
        row_wdata = '0;
        clr_nxt   = clr_r + W_S'(1);
        if (clr_r == W_S'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = acc_item;
          if (acc_item.req_type == RT_BAD || ((acc_item.req_type == RT_FILL) != pend_r)) begin
            state_nxt = ST_REJ;
          end else if (acc_item.req_type == RT_FILL) begin
            dm_we    = 1'b1;
            dm_waddr = f_idx(f_set(paddr_r), vict_r, fcnt_r);
            dm_wdata = acc_item.data_word;
            if (fcnt_r == W_O'(WORDS_PER_LINE - 1)) begin
              row_re    = 1'b1;
              row_raddr = f_set(paddr_r);
              dm_re     = 1'b1;
              dm_raddr  = f_idx(f_set(paddr_r), vict_r, f_off(paddr_r));
              state_nxt = ST_FILL;
            end else begin
              fcnt_nxt = fcnt_r + W_O'(1);
            end
          end else begin
            row_re    = 1'b1;
            row_raddr = f_set(acc_item.addr);
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        row_we = 1'b1;
        if (hit) begin
          if (req_r.req_type == RT_WRITE) begin
            row_mod[hit_way].mesi = MS_M;
            row_mod[hit_way].d    = 1'b1;
            dm_we     = 1'b1;
            dm_waddr  = f_idx(f_set(req_r.addr), hit_way, f_off(req_r.addr));
            state_nxt = (row_q[hit_way].mesi == MS_S) ? ST_UPG : ST_WDONE;
          end else begin
            dm_re     = 1'b1;
            dm_raddr  = f_idx(f_set(req_r.addr), hit_way, f_off(req_r.addr));
            state_nxt = ST_RDH;
          end
          row_wdata = f_touch(row_mod, hit_way);
        end else begin
          row_mod[victim].v    = 1'b0;
          row_mod[victim].d    = 1'b0;
          row_mod[victim].mesi = MS_I;
          row_mod[victim].age  = 8'd0;
          row_wdata = row_mod;
          pend_nxt  = 1'b1;
          pwr_nxt   = (req_r.req_type == RT_WRITE);
          paddr_nxt = req_r.addr;
          pval_nxt  = (req_r.req_type == RT_WRITE) ? req_r.data_word : 64'd0;
          vict_nxt  = victim;
          fcnt_nxt  = '0;
          wbk_nxt   = '0;
          wbtag_nxt = row_q[victim].tag;
          state_nxt = need_wb ? ST_WBRD : ST_BREQ;
        end
      end
      ST_RDH: begin
        if (can_load) begin
          out_load            = 1'b1;
          out_val.resp_kind   = RK_READ;
          out_val.out_data    = dm_q;
          out_val.was_hit     = 1'b1;
          out_val.last_of_run = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      ST_UPG: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_val.resp_kind = RK_BUSREQ;
          out_val.bus_cmd   = BC_UPG;
          out_val.out_addr  = f_base(f_tag(req_r.addr), f_set(req_r.addr));
          out_val.was_hit   = 1'b1;
          state_nxt         = ST_WDONE;
        end
      end
      ST_WDONE: begin
        if (can_load) begin
          out_load            = 1'b1;
          out_val.resp_kind   = RK_WDONE;
          out_val.was_hit     = 1'b1;
          out_val.last_of_run = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      ST_WBRD: begin
        dm_re     = 1'b1;
        dm_raddr  = f_idx(f_set(req_r.addr), vict_r, wbk_r);
        state_nxt = ST_WBOUT;
      end
      ST_WBOUT: begin
        if (can_load) begin
          out_load          = 1'b1;
          out_val.resp_kind = RK_WBWORD;
          out_val.out_addr  = f_base(wbtag_r, f_set(req_r.addr)) |
                              (16'(wbk_r) & 16'(WORDS_PER_LINE - 1));
          out_val.out_data  = dm_q;
          if (wbk_r == W_O'(WORDS_PER_LINE - 1)) begin
            state_nxt = ST_BREQ;
          end else begin
            wbk_nxt   = wbk_r + W_O'(1);
            state_nxt = ST_WBRD;
          end
        end
      end
      ST_BREQ: begin
        if (can_load) begin
          out_load            = 1'b1;
          out_val.resp_kind   = RK_BUSREQ;
          out_val.bus_cmd     = pwr_r ? BC_RDX : BC_RD;
          out_val.out_addr    = f_base(f_tag(req_r.addr), f_set(req_r.addr));
          out_val.last_of_run = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (can_load) begin
          row_mod[vict_r].v   = 1'b1;
          row_mod[vict_r].tag = f_tag(paddr_r);
          if (pwr_r) begin
            row_mod[vict_r].mesi = MS_M;
            row_mod[vict_r].d    = 1'b1;
            dm_we    = 1'b1;
            dm_waddr = f_idx(f_set(paddr_r), vict_r, f_off(paddr_r));
            dm_wdata = pval_r;
            out_val.resp_kind = RK_WDONE;
          end else begin
            row_mod[vict_r].mesi = req_r.bus_shared ? MS_S : MS_E;
            row_mod[vict_r].d    = 1'b0;
            out_val.resp_kind = RK_READ;
            out_val.out_data  = fill_word;
          end
          row_we              = 1'b1;
          row_waddr           = f_set(paddr_r);
          row_wdata           = f_touch(row_mod, vict_r);
          out_load            = 1'b1;
          out_val.last_of_run = 1'b1;
          pend_nxt            = 1'b0;
          fcnt_nxt            = '0;
          state_nxt           = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (can_load) begin
          out_load            = 1'b1;
          out_val.resp_kind   = RK_REJECT;
          out_val.last_of_run = 1'b1;
          state_nxt           = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pend_r      <= 1'b0;
      pwr_r       <= 1'b0;
      paddr_r     <= '0;
      pval_r      <= '0;
      vict_r      <= '0;
      fcnt_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      pwr_r   <= pwr_nxt;
      paddr_r <= paddr_nxt;
      pval_r  <= pval_nxt;
      vict_r  <= vict_nxt;
      fcnt_r  <= fcnt_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    wbk_r   <= wbk_nxt;
    wbtag_r <= wbtag_nxt;
    if (out_load) begin
      out_item_r <= out_val;
    end
  end

  // A line fetch request leaves the miss open until its last fill word.
  a_breq_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.resp_kind == RK_BUSREQ && out_item.bus_cmd != BC_UPG)
      |-> pend_r)
    else $error("bus fetch request without an open miss");

  // Fill words are only counted while a miss is open.
  a_fill_open: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r != '0) |-> pend_r)
    else $error("fill count running without an open miss");

  // A rejected item gives exactly one result, so it always closes its run.
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.resp_kind == RK_REJECT) |-> out_item.last_of_run)
    else $error("reject result not marked last");

endmodule

// ===== tb/cache_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the cache, keeps its own copy of the tag, state, age
// and data stores, and compares every result item against the predicted ones.
module cache_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  msac_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  msac_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_results
);
  import msac_pkg::*;

  localparam int SETS  = DEF_NUM_SETS;
  localparam int WAYS  = DEF_NUM_WAYS;
  localparam int WPL   = DEF_WORDS_PER_LINE;
  localparam int LINES = SETS * WAYS;

  logic        vld   [LINES];
  logic [1:0]  mesi  [LINES];
  logic        dirty [LINES];
  logic [7:0]  age   [LINES];
  logic [9:0]  tag   [LINES];
  logic [63:0] words [LINES * WPL];
  logic        miss_open;
  logic        miss_is_wr;
  logic [15:0] miss_addr;
  logic [63:0] miss_value;
  int          miss_way;
  int          fills_seen;

  out_item_t expected_results[$];

  assign pending_results = expected_results.size();

  function automatic out_item_t mk(logic [2:0] k, logic [1:0] c, logic [15:0] a,
                                   logic [63:0] d, logic h);
    out_item_t r;
    r.resp_kind = k;
    r.bus_cmd = c;
    r.out_addr = a;
    r.out_data = d;
    r.was_hit = h;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Every valid way in the set gets older, then the touched way becomes youngest.
  task automatic age_set(int set, int way);
    for (int w = 0; w < WAYS; w++) begin
      if (vld[set*WAYS+w] && age[set*WAYS+w] != 8'd255) age[set*WAYS+w]++;
    end
    age[set*WAYS+way] = 8'd0;
  endtask

  task automatic predict_cache(in_item_t it);
    out_item_t res[$];
    int off, blk, set, hw, v, best, oldest, idx;
    logic [9:0] tg;
    if (it.req_type == RT_BAD || ((it.req_type == RT_FILL) != miss_open)) begin
      res.push_back(mk(RK_REJECT, BC_NONE, 16'd0, 64'd0, 1'b0));
    end else if (it.req_type == RT_FILL) begin
      off = miss_addr % WPL;
      blk = miss_addr / WPL;
      set = blk % SETS;
      idx = set * WAYS + miss_way;
      words[idx*WPL+fills_seen] = it.data_word;
      fills_seen++;
      if (fills_seen >= WPL) begin
        vld[idx] = 1'b1;
        tag[idx] = 10'(blk / SETS);
        if (miss_is_wr) begin
          mesi[idx] = MS_M;
          words[idx*WPL+off] = miss_value;
          dirty[idx] = 1'b1;
        end else begin
          mesi[idx] = it.bus_shared ? MS_S : MS_E;
          dirty[idx] = 1'b0;
        end
        age_set(set, miss_way);
        if (miss_is_wr) res.push_back(mk(RK_WDONE, BC_NONE, 16'd0, 64'd0, 1'b0));
        else res.push_back(mk(RK_READ, BC_NONE, 16'd0, words[idx*WPL+off], 1'b0));
        miss_open = 1'b0;
        fills_seen = 0;
      end
    end else begin
      off = it.addr % WPL;
      blk = it.addr / WPL;
      set = blk % SETS;
      tg = 10'(blk / SETS);
      hw = WAYS;
      for (int w = 0; w < WAYS; w++) begin
        if (hw == WAYS && vld[set*WAYS+w] && tag[set*WAYS+w] == tg) hw = w;
      end
      if (hw < WAYS) begin
        idx = set * WAYS + hw;
        if (it.req_type == RT_READ) begin
          res.push_back(mk(RK_READ, BC_NONE, 16'd0, words[idx*WPL+off], 1'b1));
        end else begin
          if (mesi[idx] == MS_S)
            res.push_back(mk(RK_BUSREQ, BC_UPG, 16'(it.addr - off), 64'd0, 1'b1));
          mesi[idx] = MS_M;
          words[idx*WPL+off] = it.data_word;
          dirty[idx] = 1'b1;
          res.push_back(mk(RK_WDONE, BC_NONE, 16'd0, 64'd0, 1'b1));
        end
        age_set(set, hw);
      end else begin
        v = WAYS;
        best = -1;
        oldest = 0;
        for (int w = 0; w < WAYS; w++) begin
          if (v == WAYS) begin
            if (!vld[set*WAYS+w]) v = w;
            else if (int'(age[set*WAYS+w]) > best) begin
              best = age[set*WAYS+w];
              oldest = w;
            end
          end
        end
        if (v == WAYS) v = oldest;
        idx = set * WAYS + v;
        if (vld[idx] && (dirty[idx] || mesi[idx] == MS_M)) begin
          for (int k = 0; k < WPL; k++)
            res.push_back(mk(RK_WBWORD, BC_NONE,
                             16'((int'(tag[idx]) * SETS + set) * WPL + k),
                             words[idx*WPL+k], 1'b0));
        end
        vld[idx] = 1'b0;
        dirty[idx] = 1'b0;
        mesi[idx] = MS_I;
        age[idx] = 8'd0;
        res.push_back(mk(RK_BUSREQ, (it.req_type == RT_WRITE) ? BC_RDX : BC_RD,
                         16'(it.addr - off), 64'd0, 1'b0));
        miss_open = 1'b1;
        miss_is_wr = (it.req_type == RT_WRITE);
        miss_addr = it.addr;
        miss_value = (it.req_type == RT_WRITE) ? it.data_word : 64'd0;
        miss_way = v;
        fills_seen = 0;
      end
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[i]) expected_results.push_back(res[i]);
  endtask

  initial begin
    for (int i = 0; i < LINES; i++) begin
      vld[i] = 1'b0;
      mesi[i] = MS_I;
      dirty[i] = 1'b0;
      age[i] = 8'd0;
      tag[i] = 10'd0;
    end
    for (int i = 0; i < LINES * WPL; i++) words[i] = 64'd0;
    miss_open = 1'b0;
    miss_is_wr = 1'b0;
    miss_addr = 16'd0;
    miss_value = 64'd0;
    miss_way = 0;
    fills_seen = 0;
    fail_count = 0;
  end

  // The output side is checked before the input side is predicted; a result can
  // never come out in the same cycle as the item that causes it.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result item %p", out_item);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected %p, got %p", exp_r, out_item);
          end
        end
      end
      if (in_valid && in_ready) predict_cache(in_item);
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus for the MESI cache. A small model of the outstanding miss lets the
// driver send well-formed fill runs after most misses, with some stray fills
// and requests that collide with a pending miss mixed in as noise.
module testbench;
  import msac_pkg::*;

  localparam int WPL = DEF_WORDS_PER_LINE;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;
  int        fail_count;
  int        pending_results;

  // The stimulus side assumes that every read or write taken while no miss is outstanding
  // opens one, so that fills can follow a miss in most cases.
  logic      stim_miss;
  int        stim_fills;
  int        burst_left;

  mesi_set_assoc_cache dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  cache_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .fail_count(fail_count), .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls come in phases: sometimes always ready, sometimes mostly ready, sometimes sparse.
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Addresses are drawn from a few tags and sets so that hits, evictions and
  // writebacks of dirty lines all happen often.
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    a = 16'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      a[5:4] = 2'd0;
      a[15:9] = 7'd0;
      a[8:6] = 3'($urandom_range(0, 5));
    end
    return a;
  endfunction

  // Sends one item: holds valid until it is taken, then follows the burst pattern.
  task automatic send_item(logic [1:0] rt, logic [15:0] a, logic [63:0] d, logic sh);
    in_item_t it;
    it.req_type = rt;
    it.addr = a;
    it.data_word = d;
    it.bus_shared = sh;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (rt == RT_FILL) begin
      if (stim_miss) begin
        stim_fills++;
        if (stim_fills == WPL) begin
          stim_miss = 1'b0;
          stim_fills = 0;
        end
      end
    end else if (rt != RT_BAD && !stim_miss) begin
      stim_miss = 1'b1;
      stim_fills = 0;
    end
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic fill_line(logic sh);
    for (int k = 0; k < WPL; k++)
      send_item(RT_FILL, 16'($urandom), {$urandom, $urandom}, sh);
  endtask

  initial begin
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    stim_miss = 1'b0;
    stim_fills = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reject cases, extreme fields, shared and exclusive fills,
    // and an upgrade on a shared line.
    send_item(RT_FILL, 16'hFFFF, '1, 1'b1);
    send_item(RT_BAD, 16'hFFFF, '1, 1'b1);
    send_item(RT_READ, 16'h0000, '0, 1'b0);
    send_item(RT_WRITE, 16'h0001, '1, 1'b0);
    fill_line(1'b1);
    send_item(RT_WRITE, 16'h0002, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_item(RT_READ, 16'h0001, '0, 1'b0);
    send_item(RT_READ, 16'hFFFF, '0, 1'b0);
    send_item(RT_READ, 16'h0000, '0, 1'b0);
    fill_line(1'b0);
    send_item(RT_WRITE, 16'hFFFE, '1, 1'b1);
    send_item(RT_READ, 16'hFFFC, '1, 1'b1);
    send_item(RT_FILL, 16'h0, 64'hFFFF_0000_FFFF_0000, 1'b0);
    send_item(RT_WRITE, 16'h0003, 64'h5555_AAAA_5555_AAAA, 1'b0);

    // Random part: mostly complete miss and fill runs, some noise.
    repeat (260) begin
      r = $urandom_range(0, 99);
      if (stim_miss && r < 85) begin
        send_item(RT_FILL, 16'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (r < 4) begin
        send_item(RT_BAD, 16'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else if (!stim_miss && r < 10) begin
        send_item(RT_FILL, 16'($urandom), {$urandom, $urandom}, 1'($urandom));
      end else begin
        send_item(($urandom_range(0, 1) != 0) ? RT_WRITE : RT_READ, pick_addr(),
                  {$urandom, $urandom}, 1'($urandom));
      end
    end
    while (stim_miss) send_item(RT_FILL, 16'd0, {$urandom, $urandom}, 1'($urandom));
    // The last item was taken at this edge; drop valid unless the task already did.
    if (burst_left != 0) in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
